FILE: sv/lnr_pkg.sv
package lnr_pkg;

    localparam int SCREEN_WIDTH  = 256;
    localparam int SCREEN_HEIGHT = 256;
    localparam int FRAC_BITS     = 16;

    localparam int COORD_W = 8;
    localparam int STEP_W  = COORD_W + 1;
    localparam int QUO_W   = COORD_W + FRAC_BITS;
    localparam int SLOPE_W = QUO_W + 2;
    localparam int ICPT_W  = 18;
    localparam int NUMER_W = 2 * COORD_W + 1;
    localparam int MUL_A_W = ICPT_W + 1;
    localparam int PROD_W  = MUL_A_W + SLOPE_W;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic [7:0]         red_in;
        logic [7:0]         green_in;
        logic [7:0]         blue_in;
    } req_t;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [15:0]        pixel_index;
        logic [7:0]         red_out;
        logic [7:0]         green_out;
        logic [7:0]         blue_out;
        logic               last_pixel;
    } pix_t;

    typedef enum logic [1:0] {
        KIND_EMPTY,
        KIND_XSTEP,
        KIND_YSTEP,
        KIND_VERT
    } kind_t;

    typedef enum logic [1:0] {
        DIV_SLOPE,
        DIV_INV,
        DIV_ICPT
    } div_sel_t;

    typedef struct packed {
        logic     capture;
        logic     emit;
        logic     div_start;
        div_sel_t start_sel;
        logic     div_store;
        div_sel_t store_sel;
        logic     commit;
    } ctrl_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  div_done;
        logic  line_active;
        logic  out_full;
    } ctrl_stat_t;

endpackage

FILE: sv/lnr_div.sv
module lnr_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [lnr_pkg::QUO_W-1:0]        dividend,
    input  logic [lnr_pkg::COORD_W-1:0]      divisor,
    output logic                             done,
    output logic [lnr_pkg::QUO_W-1:0]        quotient
);

    localparam int QW    = lnr_pkg::QUO_W;
    localparam int DW    = lnr_pkg::COORD_W;
    localparam int CNT_W = $clog2(QW + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    dsr_reg, dsr_next;
    logic [QW-1:0]    quo_reg, quo_next;
    logic [DW:0]      shifted;
    logic [DW:0]      diff;
    logic             fits;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[QW-1]};
        diff      = shifted - {1'b0, dsr_reg};
        fits      = (shifted >= {1'b0, dsr_reg});
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            cnt_next = CNT_W'(QW);
            rem_next = '0;
            dsr_next = divisor;
            quo_next = dividend;
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = fits ? diff[DW-1:0] : shifted[DW-1:0];
            quo_next  = {quo_reg[QW-2:0], fits};
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: sv/lnr_datapath.sv
module lnr_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lnr_pkg::req_t          req,
    input  lnr_pkg::ctrl_cmd_t     cmd,
    input  logic                   pix_stall,
    output lnr_pkg::ctrl_stat_t    stat,
    output logic                   pix_valid,
    output lnr_pkg::pix_t          pix
);

    localparam int CW  = lnr_pkg::COORD_W;
    localparam int SW  = lnr_pkg::STEP_W;
    localparam int QW  = lnr_pkg::QUO_W;
    localparam int LW  = lnr_pkg::SLOPE_W;
    localparam int BW  = lnr_pkg::ICPT_W;
    localparam int NW  = lnr_pkg::NUMER_W;
    localparam int AW  = lnr_pkg::MUL_A_W;
    localparam int PW  = lnr_pkg::PROD_W;
    localparam int FB  = lnr_pkg::FRAC_BITS;

    localparam logic signed [PW:0] HALF_Q = (PW + 1)'(1) << (FB - 1);
    localparam logic signed [PW:0] X_MAX  = (PW + 1)'(lnr_pkg::SCREEN_WIDTH - 1);
    localparam logic signed [PW:0] Y_MAX  = (PW + 1)'(lnr_pkg::SCREEN_HEIGHT - 1);

    logic [CW-1:0]           x1_reg, y1_reg, x2_reg, y2_reg;
    logic [23:0]             color_reg;
    logic signed [NW-1:0]    numer_reg;
    logic [2*CW-1:0]         prod_a, prod_b;
    logic signed [SW-1:0]    dx, dy;
    lnr_pkg::kind_t          kind;

    logic [CW-1:0]           dy_mag;
    logic [NW-2:0]           numer_mag;
    logic [QW-1:0]           dvd;
    logic [CW-1:0]           dsr;
    logic                    neg;
    logic                    div_neg_reg;
    logic                    div_done;
    logic [QW-1:0]           quo;
    logic signed [LW-1:0]    quo_slope;
    logic signed [BW-1:0]    quo_icpt;

    logic signed [LW-1:0]    slope_reg, inv_reg;
    logic signed [BW-1:0]    b_reg;
    logic [SW-1:0]           step_reg, step_next, stop_reg;
    logic                    along_y_reg, vert_reg, active_reg;

    logic signed [AW-1:0]    a_op;
    logic signed [LW-1:0]    b_op;
    logic signed [PW-1:0]    prod_reg;

    logic signed [PW:0]      b_wide, step_wide, sum, rnd, cx_raw, cy_raw;
    logic [CW-1:0]           ox, oy;
    logic [31:0]             idx_full;
    logic                    last;

    logic                    pix_valid_reg;
    lnr_pkg::pix_t           pix_reg, pix_next;

    assign prod_a = req.end_y * req.start_x;
    assign prod_b = req.start_y * req.end_x;

    assign dx = $signed({1'b0, x2_reg}) - $signed({1'b0, x1_reg});
    assign dy = $signed({1'b0, y2_reg}) - $signed({1'b0, y1_reg});

    always_comb
    begin
        if (dx > 0 && dy <= 0)
            kind = lnr_pkg::KIND_XSTEP;
        else if (dx > 0 && dy > 0)
            kind = lnr_pkg::KIND_YSTEP;
        else if (dx == 0 && dy > 0)
            kind = lnr_pkg::KIND_VERT;
        else
            kind = lnr_pkg::KIND_EMPTY;
    end

    always_comb
    begin
        dy_mag    = dy[SW-1] ? CW'(-dy) : dy[CW-1:0];
        numer_mag = numer_reg[NW-1] ? (NW - 1)'(-numer_reg) : numer_reg[NW-2:0];
        case (cmd.start_sel)
            lnr_pkg::DIV_SLOPE:
            begin
                dvd = {dy_mag, {FB{1'b0}}};
                dsr = dx[CW-1:0];
                neg = dy[SW-1];
            end
            lnr_pkg::DIV_INV:
            begin
                dvd = {dx[CW-1:0], {FB{1'b0}}};
                dsr = dy[CW-1:0];
                neg = 1'b0;
            end
            default:
            begin
                dvd = QW'(numer_mag);
                dsr = dx[CW-1:0];
                neg = numer_reg[NW-1];
            end
        endcase
    end

    lnr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dvd),
        .divisor  (dsr),
        .done     (div_done),
        .quotient (quo)
    );

    assign quo_slope = div_neg_reg ? -$signed(LW'(quo)) : $signed(LW'(quo));
    assign quo_icpt  = div_neg_reg ? -$signed(BW'(quo)) : $signed(BW'(quo));

    always_comb
    begin
        if (cmd.commit)
            step_next = (kind == lnr_pkg::KIND_XSTEP) ? {1'b0, x1_reg} : {1'b0, y1_reg};
        else if (cmd.emit)
            step_next = step_reg + SW'(1);
        else
            step_next = step_reg;
    end

    always_comb
    begin
        if (along_y_reg)
            a_op = $signed({{(AW - SW){1'b0}}, step_next}) + $signed({b_reg[BW-1], b_reg});
        else
            a_op = $signed({{(AW - SW){1'b0}}, step_next});
        b_op = along_y_reg ? inv_reg : slope_reg;
    end

    always_comb
    begin
        b_wide    = {{(PW + 1 - BW){b_reg[BW-1]}}, b_reg};
        step_wide = $signed({{(PW + 1 - SW){1'b0}}, step_reg});
        sum       = $signed({prod_reg[PW-1], prod_reg}) + HALF_Q;
        if (!along_y_reg)
            sum = sum - (b_wide <<< FB);
        rnd = sum >>> FB;
        if (along_y_reg)
        begin
            cy_raw = step_wide;
            cx_raw = vert_reg ? b_wide : rnd;
        end
        else
        begin
            cx_raw = step_wide;
            cy_raw = rnd;
        end
        if (cx_raw < 0)
            ox = '0;
        else if (cx_raw > X_MAX)
            ox = X_MAX[CW-1:0];
        else
            ox = cx_raw[CW-1:0];
        if (cy_raw < 0)
            oy = '0;
        else if (cy_raw > Y_MAX)
            oy = Y_MAX[CW-1:0];
        else
            oy = cy_raw[CW-1:0];
        idx_full = 32'(lnr_pkg::SCREEN_WIDTH) * 32'(oy) + 32'(ox);
        last     = (({1'b0, step_reg} + (SW + 1)'(1)) >= {1'b0, stop_reg});

        pix_next.pixel_x     = ox;
        pix_next.pixel_y     = oy;
        pix_next.pixel_index = idx_full[15:0];
        pix_next.red_out     = color_reg[23:16];
        pix_next.green_out   = color_reg[15:8];
        pix_next.blue_out    = color_reg[7:0];
        pix_next.last_pixel  = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slope_reg     <= '0;
            inv_reg       <= '0;
            b_reg         <= '0;
            step_reg      <= '0;
            stop_reg      <= '0;
            along_y_reg   <= 1'b0;
            vert_reg      <= 1'b0;
            active_reg    <= 1'b0;
            color_reg     <= '0;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (cmd.capture)
            begin
                color_reg  <= {req.red_in, req.green_in, req.blue_in};
                active_reg <= 1'b0;
            end
            if (cmd.div_store)
            begin
                case (cmd.store_sel)
                    lnr_pkg::DIV_SLOPE: slope_reg <= quo_slope;
                    lnr_pkg::DIV_INV:   inv_reg   <= quo_slope;
                    default:            b_reg     <= quo_icpt;
                endcase
            end
            if (cmd.commit)
            begin
                along_y_reg <= (kind != lnr_pkg::KIND_XSTEP);
                vert_reg    <= (kind == lnr_pkg::KIND_VERT);
                stop_reg    <= (kind == lnr_pkg::KIND_XSTEP) ? {1'b0, x2_reg}
                                                             : {1'b0, y2_reg};
                active_reg  <= 1'b1;
                if (kind == lnr_pkg::KIND_VERT)
                begin
                    b_reg     <= $signed({{(BW - CW){1'b0}}, x1_reg});
                    slope_reg <= '0;
                    inv_reg   <= '0;
                end
            end
            if (cmd.emit && last)
                active_reg <= 1'b0;
            if (cmd.emit)
                pix_valid_reg <= 1'b1;
            else if (!pix_stall)
                pix_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            x1_reg    <= req.start_x;
            y1_reg    <= req.start_y;
            x2_reg    <= req.end_x;
            y2_reg    <= req.end_y;
            numer_reg <= $signed({1'b0, prod_a}) - $signed({1'b0, prod_b});
        end
        if (cmd.div_start)
            div_neg_reg <= neg;
        prod_reg <= a_op * b_op;
        if (cmd.emit)
            pix_reg <= pix_next;
    end

    assign stat.kind        = kind;
    assign stat.div_done    = div_done;
    assign stat.line_active = active_reg;
    assign stat.out_full    = pix_valid_reg;

    assign pix_valid = pix_valid_reg;
    assign pix       = pix_reg;

endmodule

FILE: sv/lnr_ctrl.sv
module lnr_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    input  logic                   req_cmd,
    input  logic                   pix_stall,
    input  lnr_pkg::ctrl_stat_t    stat,
    output logic                   req_stall,
    output lnr_pkg::ctrl_cmd_t     cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DIV_SLOPE,
        S_DIV_INV,
        S_DIV_ICPT,
        S_SETTLE
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    always_comb
    begin
        state_next    = state_reg;
        req_stall     = 1'b1;
        cmd.capture   = 1'b0;
        cmd.emit      = 1'b0;
        cmd.div_start = 1'b0;
        cmd.start_sel = lnr_pkg::DIV_SLOPE;
        cmd.div_store = 1'b0;
        cmd.store_sel = lnr_pkg::DIV_SLOPE;
        cmd.commit    = 1'b0;
        accept        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_stall = !(req_cmd == lnr_pkg::CMD_LOAD || !stat.line_active ||
                              !stat.out_full || !pix_stall);
                accept    = req_valid && !req_stall;
                if (accept && req_cmd == lnr_pkg::CMD_LOAD)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
                else if (accept)
                    cmd.emit = stat.line_active;
            end
            S_DECODE:
            begin
                unique case (stat.kind) inside
                    lnr_pkg::KIND_EMPTY:
                        state_next = S_IDLE;
                    lnr_pkg::KIND_VERT:
                    begin
                        cmd.commit = 1'b1;
                        state_next = S_SETTLE;
                    end
                    lnr_pkg::KIND_XSTEP, lnr_pkg::KIND_YSTEP:
                    begin
                        cmd.div_start = 1'b1;
                        cmd.start_sel = lnr_pkg::DIV_SLOPE;
                        state_next    = S_DIV_SLOPE;
                    end
                endcase
            end
            S_DIV_SLOPE:
            begin
                if (stat.div_done)
                begin
                    cmd.div_store = 1'b1;
                    cmd.store_sel = lnr_pkg::DIV_SLOPE;
                    cmd.div_start = 1'b1;
                    if (stat.kind == lnr_pkg::KIND_YSTEP)
                    begin
                        cmd.start_sel = lnr_pkg::DIV_INV;
                        state_next    = S_DIV_INV;
                    end
                    else
                    begin
                        cmd.start_sel = lnr_pkg::DIV_ICPT;
                        state_next    = S_DIV_ICPT;
                    end
                end
            end
            S_DIV_INV:
            begin
                if (stat.div_done)
                begin
                    cmd.div_store = 1'b1;
                    cmd.store_sel = lnr_pkg::DIV_INV;
                    cmd.div_start = 1'b1;
                    cmd.start_sel = lnr_pkg::DIV_ICPT;
                    state_next    = S_DIV_ICPT;
                end
            end
            S_DIV_ICPT:
            begin
                if (stat.div_done)
                begin
                    cmd.div_store = 1'b1;
                    cmd.store_sel = lnr_pkg::DIV_ICPT;
                    cmd.commit    = 1'b1;
                    state_next    = S_SETTLE;
                end
            end
            S_SETTLE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: sv/slope_intercept_line_raster_core.sv
// Slope-intercept line rasterizer. Requests arrive on the req channel and pixels
// leave on the pix channel; both use valid and stall, and a transaction completes
// on a clock edge with valid high and stall low.
// A load request (cmd low) captures two endpoints and a color and replaces any
// line in progress. It produces no pixel. The slope, inverse slope and intercept
// come from one shared restoring divider that retires one quotient bit per cycle.
// A load holds stall high until the line is set up: a line stepped along x needs
// the slope and intercept divisions, a line stepped along y also the inverse slope
// division, and a vertical or an empty line needs no division.
// An advance request (cmd high) emits one pixel of the active line, and the
// pixel shows on pix the cycle after its request completes. Unless a waiting pixel
// is stalled, advances are taken one per cycle: the product register always tracks
// the next step coordinate. An advance with no active line completes and
// produces nothing. The pixel that ends the line carries last_pixel. While the
// receiver stalls a waiting pixel, advances on an active line stall, but a load
// is still taken. Reset clears the line state, so no line is active afterward.
module slope_intercept_line_raster_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  lnr_pkg::req_t    req,
    output logic             pix_valid,
    input  logic             pix_stall,
    output lnr_pkg::pix_t    pix
);

    lnr_pkg::ctrl_cmd_t  cmd;
    lnr_pkg::ctrl_stat_t stat;

    lnr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_cmd   (req.cmd),
        .pix_stall (pix_stall),
        .stat      (stat),
        .req_stall (req_stall),
        .cmd       (cmd)
    );

    lnr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .pix_stall (pix_stall),
        .stat      (stat),
        .pix_valid (pix_valid),
        .pix       (pix)
    );

endmodule

FILE: sv/lnr_checker.sv
module lnr_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_stall,
    input lnr_pkg::req_t    req,
    input logic             pix_valid,
    input logic             pix_stall,
    input lnr_pkg::pix_t    pix
);

    logic load_done;

    assign load_done = req_valid && !req_stall && (req.cmd == lnr_pkg::CMD_LOAD);

    a_pix_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_stall |=> pix_valid && $stable(pix))
        else $error("pixel changed or dropped while stalled");

    a_load_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        load_done && !pix_valid |=> !pix_valid)
        else $error("load transaction produced a pixel");

    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        load_done |=> req_stall)
        else $error("request taken right after a load");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !pix_valid)
        else $error("pixel valid right after reset");

endmodule

bind slope_intercept_line_raster_core lnr_checker u_lnr_checker (.*);
